FILE: src/merge_sorter_top_macros.svh
// Assertion macros shared by the merge sorter RTL.
`ifndef MERGE_SORTER_TOP_MACROS_SVH
`define MERGE_SORTER_TOP_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define MS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold on every rising edge outside reset.
`define MS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `MS_ASSERT_IMPL(label, clk, rst, 1'b1, cond, msg)

`endif

FILE: src/ms_pkg.sv
// Package with the sizes and types of the merge sorter.
`default_nettype none

package ms_pkg;
   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = CNT_W + 2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [SUM_W-1:0]         sum_type;
   typedef logic [ADDR_W-1:0]        addr_type;

   localparam count_type CAP_COUNT = count_type'(CAPACITY);
endpackage

`default_nettype wire

FILE: src/merge_sorter_top.sv
// Top level of the merge sorter: load, bottom-up merge passes and ordered output.
`default_nettype none
`include "merge_sorter_top_macros.svh"

// Collects signed 32-bit values, one request per cycle, until a request marked last, then
// sorts them ascending and returns them in order with the final one marked last. Up to 64
// values are held; further requests are dropped and every result of that set shows
// overflow. The sort runs ceil(log2 n) passes over two buffers used in turn, each pass
// priming and then merging each pair of runs in turn, after a start state; the merge unit
// moves one element per cycle. Output then runs at one result per cycle while rsp_ready
// stays high. Requests are taken only while loading; the last result may still wait in
// the output register meanwhile.
module merge_sorter_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ms_pkg::data_type req_value,
   input  wire logic             req_last,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ms_pkg::data_type      rsp_sorted_value,
   output logic                  rsp_last_out,
   output logic                  rsp_overflow
);
   import ms_pkg::*;

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_PRIME = 3'd2;
   localparam logic [2:0] S_MERGE = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;
   count_type  count_ff, count_in;
   logic       drop_ff, drop_in;
   count_type  n_ff, n_in;
   logic       ovf_ff, ovf_in;
   logic       src_ff, src_in;
   sum_type    w_ff, w_in;
   count_type  start_ff, start_in;
   count_type  mid_ff, mid_in;
   count_type  end_ff, end_in;
   count_type  i_ff, i_in;
   count_type  j_ff, j_in;
   count_type  k_ff, k_in;
   count_type  p_ff, p_in;
   logic       ta_ff, ta_in;
   logic       tb_ff, tb_in;
   data_type   ha_ff, ha_in;
   data_type   hb_ff, hb_in;
   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_value_ff, rsp_value_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_ovf_ff, rsp_ovf_in;

   logic       accept;
   logic       fire;
   count_type  count_next;
   logic       drop_next;
   sum_type    mid_sum;
   sum_type    end_sum;
   sum_type    w_double;
   count_type  mid_c;
   count_type  end_c;
   sum_type    i_plus;
   sum_type    j_plus;
   count_type  p_plus;
   data_type   ha;
   data_type   hb;
   logic       a_ok;
   logic       b_ok;
   logic       pick_a;
   data_type   pick_val;

   addr_type            rd_addr_a;
   addr_type            rd_addr_b;
   addr_type            wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic                we0;
   logic                we1;
   logic [DATA_W-1:0]   ram0_rd_a, ram0_rd_b, ram1_rd_a, ram1_rd_b;
   data_type            src_rd_a;
   data_type            src_rd_b;

   ms_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram0 (
      .clock     (clock),
      .wr_en     (we0),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (ram0_rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (ram0_rd_b)
   );

   ms_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram1 (
      .clock     (clock),
      .wr_en     (we1),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (ram1_rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (ram1_rd_b)
   );

   assign src_rd_a = src_ff ? data_type'(ram1_rd_a) : data_type'(ram0_rd_a);
   assign src_rd_b = src_ff ? data_type'(ram1_rd_b) : data_type'(ram0_rd_b);

   assign req_ready = (state_ff == S_LOAD);
   assign accept    = req_valid && req_ready;
   assign fire      = !rsp_valid_ff || rsp_ready;

   // Run bounds of the current pair, clipped to the element count.
   assign w_double = w_ff << 1;
   assign mid_sum  = sum_type'(start_ff) + w_ff;
   assign end_sum  = sum_type'(start_ff) + w_double;
   assign mid_c    = (mid_sum > sum_type'(n_ff)) ? n_ff : count_type'(mid_sum);
   assign end_c    = (end_sum > sum_type'(n_ff)) ? n_ff : count_type'(end_sum);
   assign i_plus   = sum_type'(i_ff) + sum_type'(1);
   assign j_plus   = sum_type'(j_ff) + sum_type'(1);
   assign p_plus   = p_ff + count_type'(1);

   // A head comes straight from the read port when that side advanced last cycle.
   assign ha       = ta_ff ? src_rd_a : ha_ff;
   assign hb       = tb_ff ? src_rd_b : hb_ff;
   assign a_ok     = (i_ff < mid_ff);
   assign b_ok     = (j_ff < end_ff);
   assign pick_a   = a_ok && (!b_ok || (ha <= hb));
   assign pick_val = pick_a ? ha : hb;

   always_comb begin
      count_next = (count_ff < CAP_COUNT) ? count_ff + count_type'(1) : count_ff;
      drop_next  = drop_ff || (count_ff == CAP_COUNT);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      src_in       = src_ff;
      w_in         = w_ff;
      start_in     = start_ff;
      mid_in       = mid_ff;
      end_in       = end_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      ha_in        = ha_ff;
      hb_in        = hb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req_value;
      we0          = 1'b0;
      we1          = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               we0      = (count_ff < CAP_COUNT);
               count_in = count_next;
               drop_in  = drop_next;
               if (req_last) begin
                  n_in     = count_next;
                  ovf_in   = drop_next;
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            // Separate state so that the final load write lands before any read.
            src_in   = 1'b0;
            start_in = '0;
            w_in     = sum_type'(1);
            p_in     = '0;
            state_in = (n_ff > count_type'(1)) ? S_PRIME : S_OUT;
         end
         S_PRIME: begin
            i_in     = start_ff;
            j_in     = mid_c;
            k_in     = start_ff;
            mid_in   = mid_c;
            end_in   = end_c;
            ta_in    = 1'b1;
            tb_in    = 1'b1;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            wr_addr = k_ff[ADDR_W-1:0];
            wr_data = pick_val;
            we0     = src_ff;
            we1     = !src_ff;
            ha_in   = ha;
            hb_in   = hb;
            ta_in   = pick_a;
            tb_in   = !pick_a;
            if (pick_a) begin
               i_in = count_type'(i_plus);
            end else begin
               j_in = count_type'(j_plus);
            end
            k_in = k_ff + count_type'(1);
            if (k_in == end_ff) begin
               if (end_sum >= sum_type'(n_ff)) begin
                  src_in = !src_ff;
                  if (w_double >= sum_type'(n_ff)) begin
                     p_in     = '0;
                     state_in = S_OUT;
                  end else begin
                     w_in     = w_double;
                     start_in = '0;
                     state_in = S_PRIME;
                  end
               end else begin
                  start_in = count_type'(end_sum);
                  state_in = S_PRIME;
               end
            end
         end
         S_OUT: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = src_rd_a;
               rsp_last_in  = (p_plus == n_ff);
               rsp_ovf_in   = ovf_ff;
               p_in         = p_plus;
               if (p_plus == n_ff) begin
                  state_in = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // The output reads the address that p will hold, so the registered read returns that entry while p holds it.
      if (state_in == S_OUT) begin
         rd_addr_a = p_in[ADDR_W-1:0];
      end else if (state_ff == S_PRIME) begin
         rd_addr_a = start_ff[ADDR_W-1:0];
      end else begin
         rd_addr_a = i_plus[ADDR_W-1:0];
      end
      rd_addr_b = (state_ff == S_PRIME) ? mid_c[ADDR_W-1:0] : j_plus[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      ovf_ff       <= ovf_in;
      src_ff       <= src_in;
      w_ff         <= w_in;
      start_ff     <= start_in;
      mid_ff       <= mid_in;
      end_ff       <= end_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      p_ff         <= p_in;
      ta_ff        <= ta_in;
      tb_ff        <= tb_in;
      ha_ff        <= ha_in;
      hb_ff        <= hb_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   `MS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CAP_COUNT,
      "element count exceeds capacity")
   `MS_ASSERT_IMPL(a_merge_live, clock, reset, state_ff == S_MERGE,
      (i_ff < mid_ff || j_ff < end_ff) && k_ff < n_ff, "merge step with both runs exhausted")
   `MS_ASSERT_IMPL(a_out_range, clock, reset, state_ff == S_OUT,
      p_ff < n_ff, "output pointer beyond the loaded set")
endmodule

`default_nettype wire

FILE: src/ms_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module ms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   output logic      [WIDTH-1:0]           rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic      [WIDTH-1:0]           rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;
endmodule

`default_nettype wire

FILE: test/merge_sorter_checker.sv
// Checker for the merge sorter: predicts each sorted set and compares every result.
`timescale 1ns / 100ps

module merge_sorter_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire ms_pkg::data_type req_value,
   input  wire logic             req_last,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire ms_pkg::data_type rsp_sorted_value,
   input  wire logic             rsp_last_out,
   input  wire logic             rsp_overflow,
   output int                    fail_count,
   output int                    pending_results,
   output int                    checked_results
);
   import ms_pkg::*;

   typedef struct {
      data_type value;
      logic     last_out;
      logic     overflow;
   } sorted_entry_type;

   sorted_entry_type expected_order[$];
   sorted_entry_type oldest;

   // Copy of the set being loaded, with its fill level and drop flag.
   data_type load_buf[CAPACITY];
   int       load_count;
   logic     load_dropped;

   data_type key;
   int       j;

   initial begin
      fail_count      = 0;
      checked_results = 0;
      pending_results = 0;
      load_count      = 0;
      load_dropped    = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         load_count   = 0;
         load_dropped = 1'b0;
         expected_order.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_order.size() == 0) begin
               $display("%0t: unexpected result, expected none, got value %0d last %b overflow %b",
                        $time, rsp_sorted_value, rsp_last_out, rsp_overflow);
               fail_count++;
            end else begin
               oldest = expected_order.pop_front();
               checked_results++;
               if (rsp_sorted_value !== oldest.value) begin
                  $display("%0t: sorted_value expected %0d, got %0d",
                           $time, oldest.value, rsp_sorted_value);
                  fail_count++;
               end
               if (rsp_last_out !== oldest.last_out) begin
                  $display("%0t: last_out expected %b, got %b",
                           $time, oldest.last_out, rsp_last_out);
                  fail_count++;
               end
               if (rsp_overflow !== oldest.overflow) begin
                  $display("%0t: overflow expected %b, got %b",
                           $time, oldest.overflow, rsp_overflow);
                  fail_count++;
               end
            end
         end

         if (req_valid && req_ready) begin
            if (load_count < CAPACITY) begin
               load_buf[load_count] = req_value;
               load_count++;
            end else begin
               load_dropped = 1'b1;
            end

            if (req_last) begin
               // A strict comparison keeps equal values in arrival order.
               for (int i = 1; i < load_count; i++) begin
                  key = load_buf[i];
                  j   = i - 1;
                  while (j >= 0 && load_buf[j] > key) begin
                     load_buf[j+1] = load_buf[j];
                     j--;
                  end
                  load_buf[j+1] = key;
               end
               for (int k = 0; k < load_count; k++) begin
                  expected_order.push_back('{load_buf[k], (k == load_count - 1), load_dropped});
               end
               load_count   = 0;
               load_dropped = 1'b0;
            end
         end
      end
      pending_results = expected_order.size();
   end
endmodule

FILE: test/testbench.sv
// Testbench top for the merge sorter: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
   import ms_pkg::*;

   localparam data_type VALUE_MIN   = 32'sh8000_0000;
   localparam data_type VALUE_MAX   = 32'sh7fff_ffff;
   localparam int       ITEM_TARGET = 460;
   localparam int       CYCLE_LIMIT = 300000;
   localparam int       HOLD_CYCLES = 1500;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   data_type req_value = '0;
   logic     req_last  = 1'b0;
   logic     rsp_ready = 1'b0;
   logic     req_ready;
   logic     rsp_valid;
   data_type rsp_sorted_value;
   logic     rsp_last_out;
   logic     rsp_overflow;

   int fail_count;
   int pending_results;
   int checked_results;

   int   cycle_count = 0;
   int   items_sent  = 0;
   int   sets_sent   = 0;
   int   full_sets   = 0;
   logic start_hold  = 1'b0;
   logic hold_done   = 1'b0;

   merge_sorter_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   merge_sorter_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .checked_results  (checked_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_results);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic data_type pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3:    return data_type'($urandom_range(0, 6)) - 3;
         default: return data_type'($urandom);
      endcase
   endfunction

   // Offers one request and returns just after the edge that takes it, sometimes
   // followed by an idle gap on the request side.
   task automatic send_req(input data_type value, input logic last);
      req_valid <= 1'b1;
      req_value <= value;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (last) sets_sent++;
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   task automatic send_set(input int length);
      if (length > CAPACITY) full_sets++;
      for (int i = 0; i < length; i++) send_req(pick_value(), i == length - 1);
   endtask

   // Response side: random stalls, long ready stretches and one long hold-off.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (start_hold && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len() - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 80)) @(posedge clock);
         end
      end
   end

   initial begin
      int length;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets: single extremes, mixed extremes, equal values, a reversed pair.
      send_req(VALUE_MIN, 1'b1);
      send_req(VALUE_MAX, 1'b1);
      send_req(VALUE_MAX, 1'b0);
      send_req(VALUE_MIN, 1'b0);
      send_req(32'sd0, 1'b0);
      send_req(-32'sd1, 1'b0);
      send_req(32'sd1, 1'b0);
      send_req(VALUE_MIN, 1'b1);
      send_req(32'sh5555_5555, 1'b0);
      send_req(32'sh5555_5555, 1'b0);
      send_req(32'sh5555_5555, 1'b1);
      send_req(32'sh5555_5555, 1'b0);
      send_req(32'shaaaa_aaaa, 1'b1);

      // Full and overfull sets first, while the response side holds off, so that the
      // block fills up and stops taking requests.
      start_hold <= 1'b1;
      send_set(CAPACITY);
      send_set(CAPACITY + 1);
      send_set(CAPACITY + 6);

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:             length = $urandom_range(CAPACITY - 4, CAPACITY + 8);
            1, 2:          length = $urandom_range(9, 32);
            default:       length = $urandom_range(1, 8);
         endcase
         send_set(length);
      end
      req_valid <= 1'b0;

      // Let the checker record the final request before waiting on its results.
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Sorted %0d sets from %0d requests, %0d of them beyond capacity;",
               sets_sent, items_sent, full_sets);
      $display("%0d results checked under random stalls and one long output hold-off.",
               checked_results);
      if (fail_count == 0 && pending_results == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+src
src/ms_pkg.sv
src/ms_ram.sv
src/merge_sorter_top.sv
test/merge_sorter_checker.sv
test/testbench.sv
